// ===== hdl/bdll_pkg.sv =====
// ----------------------------------------------------------------------------
// bdll_pkg: shared types and constants for the bounded doubly linked list
// Holds the request and response words, the operation and status codes and
// the command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdll_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LNK_W = IDX_W + 1;
   localparam int VAL_W = 32;

   localparam logic [LNK_W-1:0] LINK_NULL = LNK_W'(DEPTH);
   localparam logic [LNK_W-1:0] DEPTH_CNT = LNK_W'(DEPTH);

   // operations
   localparam logic [2:0] OP_APPEND  = 3'd0;
   localparam logic [2:0] OP_PREPEND = 3'd1;
   localparam logic [2:0] OP_INSERT  = 3'd2;
   localparam logic [2:0] OP_SEARCH  = 3'd3;
   localparam logic [2:0] OP_POP_F   = 3'd4;
   localparam logic [2:0] OP_POP_B   = 3'd5;
   localparam logic [2:0] OP_REMOVE  = 3'd6;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_POS   = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   // datapath commands
   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_LOAD     = 4'd1;  // latch request, start walk at head
   localparam logic [3:0] CMD_RD_CUR   = 4'd2;  // read value and links of cursor
   localparam logic [3:0] CMD_STEP     = 4'd3;  // advance cursor along next link
   localparam logic [3:0] CMD_POP_FREE = 4'd4;  // read free stack top
   localparam logic [3:0] CMD_LINK     = 4'd5;  // write new node and neighbor links
   localparam logic [3:0] CMD_UNLINK   = 4'd6;  // patch neighbors, push node
   localparam logic [3:0] CMD_SET_END  = 4'd7;  // cursor := head or tail
   localparam logic [3:0] CMD_INIT     = 4'd8;  // free stack fill step

   typedef struct packed {
      logic [2:0]       mode;
      logic [6:0]       position;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] found_index;
      logic [6:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic       use_tail;
   } cmd_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [6:0]       position;
      logic             full;
      logic             empty;
      logic             pos_bad;
      logic             cur_null;
      logic             hit;
      logic             at_pos;
      logic             at_end;
      logic             init_done;
   } stat_type;

endpackage

// ===== hdl/bounded_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list: ordered list of up to 64 signed 32-bit values
// Request word: mode, position, value. Response word: status, found_index,
// entry_count. One response per request, in order.
//
// Nodes live in RAMs for value, next and prev links; free nodes sit on a
// stack RAM. Search, positional insert and value removal walk the links
// with one RAM read per node; the walk loop through the next link RAM
// sets their pace. After reset the free stack is filled, one entry per
// cycle, for all 64 entries; no request is taken meanwhile. One request
// is worked at a time. The response register holds a finished word while
// rsp_ready is low; a new request is taken in the same cycle the old word
// leaves.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdll_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdll_pkg::rsp_type rsp_data
);

   bdll_pkg::cmd_type  cmd;
   bdll_pkg::stat_type stat;
   logic [6:0]         pos_w, count_w;

   bdll_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp_data),
      .stat(stat), .pos_in_dp(pos_w), .count_in_dp(count_w), .cmd(cmd));

   bdll_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd),
      .stat(stat), .pos_out(pos_w), .count_out(count_w));

endmodule

// ===== hdl/bdll_ram.sv =====
// ----------------------------------------------------------------------------
// bdll_ram: generic single port RAM with registered read
// One address per cycle: an optional write and a read, which returns the old word.
// ----------------------------------------------------------------------------
module bdll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // optional write and a read of the old word, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

// ===== hdl/bdll_datapath.sv =====
// ----------------------------------------------------------------------------
// bdll_datapath: node store, free stack, head, tail and walk cursor
// Executes one controller command per cycle. RAM reads return in the next cycle.
// ----------------------------------------------------------------------------
module bdll_datapath (
   input  logic                clock,
   input  logic                reset,
   input  bdll_pkg::req_type   req,
   input  bdll_pkg::cmd_type   cmd,
   output bdll_pkg::stat_type  stat,
   output logic [6:0]          pos_out,
   output logic [6:0]          count_out
);

   localparam int IW = bdll_pkg::IDX_W;
   localparam int LW = bdll_pkg::LNK_W;
   localparam int VW = bdll_pkg::VAL_W;

   logic [2:0]    mode_ff, mode_in;
   logic [6:0]    position_ff, position_in;
   logic [VW-1:0] value_ff, value_in;
   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in, len_ff, len_in;
   logic [LW-1:0] cur_ff, cur_in, bef_ff, bef_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] init_ff, init_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [LW-1:0] nprev_ff, nprev_in, nnext_ff, nnext_in;
   logic [2:0]    phase_ff, phase_in;

   // RAM ports
   logic          v_we, n_we, p_we, f_we;
   logic [IW-1:0] v_a, n_a, p_a, f_a;
   logic [VW-1:0] v_wd, v_rd;
   logic [LW-1:0] n_wd, n_rd, p_wd, p_rd;
   logic [IW-1:0] f_wd, f_rd;

   bdll_ram #(.WIDTH(VW), .DEPTH(bdll_pkg::DEPTH)) u_val (
      .clock(clock), .wr_en(v_we), .addr(v_a), .wr_data(v_wd), .rd_data(v_rd));
   bdll_ram #(.WIDTH(LW), .DEPTH(bdll_pkg::DEPTH)) u_next (
      .clock(clock), .wr_en(n_we), .addr(n_a), .wr_data(n_wd), .rd_data(n_rd));
   bdll_ram #(.WIDTH(LW), .DEPTH(bdll_pkg::DEPTH)) u_prev (
      .clock(clock), .wr_en(p_we), .addr(p_a), .wr_data(p_wd), .rd_data(p_rd));
   bdll_ram #(.WIDTH(IW), .DEPTH(bdll_pkg::DEPTH)) u_free (
      .clock(clock), .wr_en(f_we), .addr(f_a), .wr_data(f_wd), .rd_data(f_rd));

   logic [LW-1:0] free_top;
   logic [LW-1:0] newn;
   assign free_top = bdll_pkg::DEPTH_CNT - len_ff;
   assign newn     = {1'b0, f_rd};

   // link updates are done over phases: phase counts write slots
   always_comb begin
      mode_in     = mode_ff;
      position_in = position_ff;
      value_in    = value_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      len_in      = len_ff;
      cur_in      = cur_ff;
      bef_in      = bef_ff;
      pos_in      = pos_ff;
      init_in     = init_ff;
      rd_pend_in  = 1'b0;
      nprev_in    = nprev_ff;
      nnext_in    = nnext_ff;
      phase_in    = 3'd0;
      v_we = 1'b0; n_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
      v_a  = cur_ff[IW-1:0];
      n_a  = cur_ff[IW-1:0];
      p_a  = cur_ff[IW-1:0];
      f_a  = IW'(free_top - LW'(1));
      v_wd = value_ff;
      n_wd = bdll_pkg::LINK_NULL;
      p_wd = bdll_pkg::LINK_NULL;
      f_wd = cur_ff[IW-1:0];
      unique case (cmd.op)
         bdll_pkg::CMD_LOAD: begin
            mode_in     = req.mode;
            position_in = req.position;
            value_in    = req.value;
            cur_in      = head_ff;
            bef_in      = bdll_pkg::LINK_NULL;
            pos_in      = '0;
         end
         bdll_pkg::CMD_SET_END: begin
            cur_in = cmd.use_tail ? tail_ff : head_ff;
         end
         bdll_pkg::CMD_RD_CUR: begin
            rd_pend_in = 1'b1;
         end
         bdll_pkg::CMD_STEP: begin
            bef_in = cur_ff;
            cur_in = n_rd;
            pos_in = pos_ff + LW'(1);
         end
         bdll_pkg::CMD_POP_FREE: begin
            // free stack top read, lands next cycle
            f_a = IW'(free_top - LW'(1));
            if (mode_ff == bdll_pkg::OP_APPEND) begin
               bef_in = tail_ff;
               cur_in = bdll_pkg::LINK_NULL;
            end else if (mode_ff == bdll_pkg::OP_PREPEND) begin
               bef_in = bdll_pkg::LINK_NULL;
               cur_in = head_ff;
            end
         end
         bdll_pkg::CMD_LINK: begin
            // slot 0: write the new node; slot 1: patch before and after
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd0) begin
               nnext_in = newn;
               v_we = 1'b1; n_we = 1'b1; p_we = 1'b1;
               v_a = newn[IW-1:0]; n_a = newn[IW-1:0]; p_a = newn[IW-1:0];
               n_wd = cur_ff; p_wd = bef_ff;
               if (bef_ff == bdll_pkg::LINK_NULL) head_in = newn;
               else begin
                  n_a = newn[IW-1:0];
               end
            end else if (phase_ff == 3'd1) begin
               if (bef_ff != bdll_pkg::LINK_NULL) begin
                  n_we = 1'b1; n_a = bef_ff[IW-1:0]; n_wd = nnext_ff;
               end
               if (cur_ff != bdll_pkg::LINK_NULL) begin
                  p_we = 1'b1; p_a = cur_ff[IW-1:0]; p_wd = nnext_ff;
               end else begin
                  tail_in = nnext_ff;
               end
               len_in   = len_ff + LW'(1);
               phase_in = 3'd0;
            end
         end
         bdll_pkg::CMD_UNLINK: begin
            // cursor node links are in n_rd/p_rd from a prior read
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd0) begin
               nprev_in = p_rd;
               nnext_in = n_rd;
            end else begin
               if (nprev_ff != bdll_pkg::LINK_NULL) begin
                  n_we = 1'b1; n_a = nprev_ff[IW-1:0]; n_wd = nnext_ff;
               end else begin
                  head_in = nnext_ff;
               end
               if (nnext_ff != bdll_pkg::LINK_NULL) begin
                  p_we = 1'b1; p_a = nnext_ff[IW-1:0]; p_wd = nprev_ff;
               end else begin
                  tail_in = nprev_ff;
               end
               f_we = 1'b1; f_a = IW'(free_top); f_wd = cur_ff[IW-1:0];
               len_in   = len_ff - LW'(1);
               phase_in = 3'd0;
            end
         end
         bdll_pkg::CMD_INIT: begin
            f_we    = 1'b1;
            f_a     = init_ff[IW-1:0];
            f_wd    = IW'(LW'(bdll_pkg::DEPTH - 1) - init_ff);
            init_in = init_ff + LW'(1);
         end
         default: begin
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= bdll_pkg::LINK_NULL;
         tail_ff    <= bdll_pkg::LINK_NULL;
         len_ff     <= '0;
         init_ff    <= '0;
         rd_pend_ff <= 1'b0;
         phase_ff   <= 3'd0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         len_ff     <= len_in;
         init_ff    <= init_in;
         rd_pend_ff <= rd_pend_in;
         phase_ff   <= phase_in;
      end
      mode_ff     <= mode_in;
      position_ff <= position_in;
      value_ff    <= value_in;
      cur_ff      <= cur_in;
      bef_ff      <= bef_in;
      pos_ff      <= pos_in;
      nprev_ff    <= nprev_in;
      nnext_ff    <= nnext_in;
   end

   // status toward the controller
   always_comb begin
      stat.mode      = mode_ff;
      stat.position  = position_ff;
      stat.full      = (len_ff == bdll_pkg::DEPTH_CNT);
      stat.empty     = (len_ff == '0);
      stat.pos_bad   = ({1'b0, position_ff} > {1'b0, len_ff});
      stat.cur_null  = (cur_ff == bdll_pkg::LINK_NULL) || (pos_ff >= len_ff);
      stat.hit       = rd_pend_ff && (v_rd == value_ff);
      stat.at_pos    = (pos_ff == LW'(position_ff));
      stat.at_end    = (phase_ff != 3'd0);
      stat.init_done = (init_ff == bdll_pkg::DEPTH_CNT);
   end

   assign pos_out   = 7'(pos_ff);
   assign count_out = 7'(len_ff);

   // assertions
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= bdll_pkg::DEPTH_CNT) else $error("length above depth");
   a_empty_null: assert property (@(posedge clock) disable iff (reset)
      (len_ff == '0 && init_ff == bdll_pkg::DEPTH_CNT && phase_ff == 3'd0)
      |-> head_ff == bdll_pkg::LINK_NULL)
      else $error("empty list with head");
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      (len_ff != $past(len_ff)) |-> (len_ff == $past(len_ff) + LW'(1) ||
      len_ff == $past(len_ff) - LW'(1))) else $error("length jumped");

endmodule

// ===== hdl/bdll_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdll_ctrl: controller for the linked list
// Sequences the free stack fill, the link walk and the updates, and holds
// the response word until taken.
// ----------------------------------------------------------------------------
module bdll_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bdll_pkg::rsp_type   rsp,
   input  bdll_pkg::stat_type  stat,
   input  logic [6:0]          pos_in_dp,
   input  logic [6:0]          count_in_dp,
   output bdll_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DISP  = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_POP   = 4'd5;
   localparam logic [3:0] S_LNK0  = 4'd6;
   localparam logic [3:0] S_LNK1  = 4'd7;
   localparam logic [3:0] S_URD   = 4'd8;
   localparam logic [3:0] S_UN0   = 4'd9;
   localparam logic [3:0] S_UN1   = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;
   localparam logic [3:0] S_END   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   bdll_pkg::rsp_type rsp_ff, rsp_in;
   logic [2:0] st_ff, st_in;
   logic [5:0] fi_ff, fi_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      st_in        = st_ff;
      fi_in        = fi_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op       = bdll_pkg::CMD_NONE;
      cmd.use_tail = 1'b0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            if (stat.init_done) state_in = S_IDLE;
            else cmd.op = bdll_pkg::CMD_INIT;
         end
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.op   = bdll_pkg::CMD_LOAD;
               st_in    = bdll_pkg::ST_OK;
               fi_in    = '0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.mode)
               bdll_pkg::OP_APPEND, bdll_pkg::OP_PREPEND: begin
                  if (stat.full) begin
                     st_in = bdll_pkg::ST_FULL; state_in = S_DONE;
                  end else state_in = S_POP;
               end
               bdll_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     st_in = bdll_pkg::ST_FULL; state_in = S_DONE;
                  end else if (stat.pos_bad) begin
                     st_in = bdll_pkg::ST_BAD_POS; state_in = S_DONE;
                  end else state_in = S_RD;
               end
               bdll_pkg::OP_SEARCH, bdll_pkg::OP_REMOVE: state_in = S_RD;
               bdll_pkg::OP_POP_F, bdll_pkg::OP_POP_B: begin
                  if (stat.empty) begin
                     st_in = bdll_pkg::ST_EMPTY; state_in = S_DONE;
                  end else begin
                     cmd.op       = bdll_pkg::CMD_SET_END;
                     cmd.use_tail = (stat.mode == bdll_pkg::OP_POP_B);
                     state_in     = S_URD;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RD: begin
            // walk: stop at position for insert, or at list end
            if (stat.mode == bdll_pkg::OP_INSERT && (stat.at_pos || stat.cur_null)) begin
               state_in = S_POP;
            end else if (stat.mode != bdll_pkg::OP_INSERT && stat.cur_null) begin
               st_in = bdll_pkg::ST_NOT_FOUND; state_in = S_DONE;
            end else begin
               cmd.op   = bdll_pkg::CMD_RD_CUR;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.mode != bdll_pkg::OP_INSERT && stat.hit) begin
               if (stat.mode == bdll_pkg::OP_SEARCH) begin
                  fi_in = pos_in_dp[5:0]; state_in = S_DONE;
               end else begin
                  cmd.op = bdll_pkg::CMD_UNLINK; state_in = S_UN1;
               end
            end else begin
               cmd.op   = bdll_pkg::CMD_STEP;
               state_in = S_RD;
            end
         end
         S_POP: begin
            cmd.op   = bdll_pkg::CMD_POP_FREE;
            state_in = S_LNK0;
         end
         S_LNK0: begin
            cmd.op   = bdll_pkg::CMD_LINK;
            state_in = S_LNK1;
         end
         S_LNK1: begin
            cmd.op   = bdll_pkg::CMD_LINK;
            state_in = S_DONE;
         end
         S_URD: begin
            cmd.op   = bdll_pkg::CMD_RD_CUR;
            state_in = S_UN0;
         end
         S_UN0: begin
            cmd.op   = bdll_pkg::CMD_UNLINK;
            state_in = S_UN1;
         end
         S_UN1: begin
            cmd.op   = bdll_pkg::CMD_UNLINK;
            state_in = S_DONE;
         end
         S_DONE: begin
            // count settles this cycle; drive the word next
            state_in = S_END;
         end
         S_END: begin
            rsp_in.status      = st_ff;
            rsp_in.found_index = fi_ff;
            rsp_in.entry_count = count_in_dp;
            rsp_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // hold state and response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      st_ff  <= st_in;
      fi_ff  <= fi_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // assertions
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END) |-> (!rsp_valid_ff || rsp_ready)) else $error("response overrun");
   a_fi_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END && fi_ff != '0) |-> stat.mode == bdll_pkg::OP_SEARCH)
      else $error("found index on non-search");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded doubly linked list
// Drives request words with random gaps, keeps its own model of the list,
// and checks every response word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   // mode code that names no operation
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   bdll_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   bdll_pkg::rsp_type rsp_data;

   // model of the list contents, front first
   logic [bdll_pkg::VAL_W-1:0] list_model[$];
   bdll_pkg::rsp_type          expected_rsp[$];
   int                         error_count;
   int                         hold_cycles;

   bounded_doubly_linked_list i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   // compute the response for one word and update the list model
   function automatic bdll_pkg::rsp_type list_apply(input bdll_pkg::req_type rq);
      bdll_pkg::rsp_type r;
      int                p;
      r = '0;
      p = -1;
      if (rq.mode inside {bdll_pkg::OP_SEARCH, bdll_pkg::OP_REMOVE})
         foreach (list_model[i])
            if (p < 0 && list_model[i] == rq.value) p = i;
      case (rq.mode)
         bdll_pkg::OP_APPEND, bdll_pkg::OP_PREPEND, bdll_pkg::OP_INSERT: begin
            if (list_model.size() >= bdll_pkg::DEPTH) r.status = bdll_pkg::ST_FULL;
            else if (rq.mode == bdll_pkg::OP_APPEND) list_model.push_back(rq.value);
            else if (rq.mode == bdll_pkg::OP_PREPEND) list_model.push_front(rq.value);
            else if (rq.position > list_model.size()) r.status = bdll_pkg::ST_BAD_POS;
            else list_model.insert(rq.position, rq.value);
         end
         bdll_pkg::OP_SEARCH: begin
            if (p < 0) r.status = bdll_pkg::ST_NOT_FOUND;
            else r.found_index = p[5:0];
         end
         bdll_pkg::OP_POP_F, bdll_pkg::OP_POP_B: begin
            if (list_model.size() == 0) r.status = bdll_pkg::ST_EMPTY;
            else if (rq.mode == bdll_pkg::OP_POP_F) void'(list_model.pop_front());
            else void'(list_model.pop_back());
         end
         bdll_pkg::OP_REMOVE: begin
            if (p < 0) r.status = bdll_pkg::ST_NOT_FOUND;
            else list_model.delete(p);
         end
         default: ;
      endcase
      r.entry_count = 7'(list_model.size());
      return r;
   endfunction

   // send one word after a random gap
   task automatic send_word(input logic [2:0] mode, input logic [6:0] pos,
                            input logic [31:0] val);
      bdll_pkg::req_type rq;
      int                gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      // drop valid only when a gap follows
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      rq.mode = mode;
      rq.position = pos;
      rq.value = val;
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.push_back(list_apply(rq));
      @(negedge clock);
   endtask

   // receiver stall control
   initial begin
      int wait_n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (rsp_ready && !(rsp_valid)) begin
            rsp_ready <= 1'b1;
         end else begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (wait_n == 0) rsp_ready <= 1'b1;
            else begin
               rsp_ready <= 1'b0;
               repeat (wait_n - 1) @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // check each response word against the oldest expectation
   always @(posedge clock) begin
      bdll_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report("unexpected word", rsp_data.status, -1);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status != want.status)
               report("status", rsp_data.status, want.status);
            if (rsp_data.found_index != want.found_index)
               report("found_index", rsp_data.found_index, want.found_index);
            if (rsp_data.entry_count != want.entry_count)
               report("entry_count", rsp_data.entry_count, want.entry_count);
         end
      end
   end

   function automatic logic [31:0] pick_value();
      // mostly present values so that search and remove hit
      if (list_model.size() > 0 && $urandom_range(0, 2) != 0)
         return list_model[$urandom_range(0, list_model.size() - 1)];
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
      return $urandom;
   endfunction

   task automatic drain_list();
      while (list_model.size() > 0) send_word(bdll_pkg::OP_POP_B, '0, '0);
   endtask

   task automatic test_directed();
      send_word(bdll_pkg::OP_POP_F, '0, '0);
      send_word(bdll_pkg::OP_POP_B, '0, '0);
      send_word(bdll_pkg::OP_SEARCH, '0, 32'd5);
      send_word(bdll_pkg::OP_REMOVE, '0, 32'd5);
      send_word(bdll_pkg::OP_INSERT, 7'd1, 32'd1);
      send_word(bdll_pkg::OP_INSERT, 7'd0, 32'h8000_0000);
      send_word(bdll_pkg::OP_APPEND, 7'h7f, 32'h7fff_ffff);
      send_word(bdll_pkg::OP_PREPEND, '0, 32'hffff_ffff);
      send_word(bdll_pkg::OP_INSERT, 7'd3, 32'd0);
      send_word(bdll_pkg::OP_INSERT, 7'd2, 32'h7fff_ffff);
      send_word(bdll_pkg::OP_SEARCH, '0, 32'h7fff_ffff);
      send_word(bdll_pkg::OP_SEARCH, '0, 32'd0);
      send_word(OP_UNUSED, 7'h7f, 32'hffff_ffff);
      send_word(bdll_pkg::OP_REMOVE, '0, 32'h7fff_ffff);
      send_word(bdll_pkg::OP_POP_F, '0, '0);
      send_word(bdll_pkg::OP_POP_B, '0, '0);
      send_word(bdll_pkg::OP_INSERT, 7'd64, 32'd9);
   endtask

   // fill to capacity, then hit store full on every insert kind
   task automatic test_full_store();
      while (list_model.size() < bdll_pkg::DEPTH)
         send_word(($urandom_range(0, 1) == 0) ? bdll_pkg::OP_APPEND : bdll_pkg::OP_PREPEND,
                   '0, $urandom);
      send_word(bdll_pkg::OP_APPEND, '0, 32'd1);
      send_word(bdll_pkg::OP_PREPEND, '0, 32'd1);
      send_word(bdll_pkg::OP_INSERT, 7'd100, 32'd1);
      send_word(bdll_pkg::OP_SEARCH, '0, list_model[bdll_pkg::DEPTH-1]);
      send_word(bdll_pkg::OP_REMOVE, '0, list_model[bdll_pkg::DEPTH-1]);
      send_word(bdll_pkg::OP_INSERT, 7'd63, 32'd2);
      send_word(bdll_pkg::OP_INSERT, 7'd64, 32'd2);
      drain_list();
   endtask

   // receiver holds off while sender keeps offering words
   task automatic test_backpressure();
      hold_cycles = 400;
      repeat (30) send_word(bdll_pkg::OP_APPEND, '0, $urandom);
      drain_list();
   endtask

   task automatic test_random(input int n);
      logic [2:0] m;
      logic [6:0] p;
      repeat (n) begin
         m = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 4) == 0) p = 7'($urandom);
         else p = 7'($urandom_range(0, list_model.size()));
         send_word(m, p, pick_value());
      end
   endtask

   initial begin
      int guard;
      error_count = 0;
      hold_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      test_backpressure();
      test_random(1500);
      req_valid <= 1'b0;
      guard = 0;
      while (expected_rsp.size() > 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
